// ----- src/sdspi_pkg.sv -----
`default_nettype none
package sdspi_pkg;

  localparam int BlockBytesDefault = 512;

  localparam logic [1:0] ACT_INIT  = 2'd0;
  localparam logic [1:0] ACT_READ  = 2'd1;
  localparam logic [1:0] ACT_BYTE  = 2'd2;
  localparam logic [1:0] ACT_DELAY = 2'd3;

  localparam logic [3:0] PH_IDLE    = 4'd0;
  localparam logic [3:0] PH_DELAY   = 4'd1;
  localparam logic [3:0] PH_CLK     = 4'd2;
  localparam logic [3:0] PH_FRAME   = 4'd3;
  localparam logic [3:0] PH_POLL    = 4'd4;
  localparam logic [3:0] PH_TRAIL   = 4'd5;
  localparam logic [3:0] PH_RELEASE = 4'd6;
  localparam logic [3:0] PH_TOKEN   = 4'd7;
  localparam logic [3:0] PH_DATA    = 4'd8;
  localparam logic [3:0] PH_CRC     = 4'd9;
  localparam logic [3:0] PH_DONE    = 4'd10;

  localparam logic [2:0] RL_EVAL0   = 3'd0;
  localparam logic [2:0] RL_EVAL8   = 3'd1;
  localparam logic [2:0] RL_AFTER55 = 3'd2;
  localparam logic [2:0] RL_EVAL41  = 3'd3;
  localparam logic [2:0] RL_EVAL58  = 3'd4;
  localparam logic [2:0] RL_FAIL5   = 3'd5;
  localparam logic [2:0] RL_FAIL6   = 3'd6;
  localparam logic [2:0] RL_OK      = 3'd7;

  localparam logic [1:0] DL_PWR = 2'd0;
  localparam logic [1:0] DL_RST = 2'd1;
  localparam logic [1:0] DL_ACT = 2'd2;

  localparam logic [5:0] CMD_GO_IDLE  = 6'd0;
  localparam logic [5:0] CMD_IF_COND  = 6'd8;
  localparam logic [5:0] CMD_READ     = 6'd17;
  localparam logic [5:0] CMD_OP_COND  = 6'd41;
  localparam logic [5:0] CMD_APP      = 6'd55;
  localparam logic [5:0] CMD_READ_OCR = 6'd58;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_NO_IDLE = 3'd1;
  localparam logic [2:0] ST_CMD8    = 3'd2;
  localparam logic [2:0] ST_ACMD41  = 3'd3;
  localparam logic [2:0] ST_CMD58   = 3'd4;
  localparam logic [2:0] ST_REJECT  = 3'd5;
  localparam logic [2:0] ST_TOKEN   = 3'd6;

  localparam logic [2:0] CFG_RESET_TRIES   = 3'd0;
  localparam logic [2:0] CFG_ACT_TRIES     = 3'd1;
  localparam logic [2:0] CFG_TOKEN_LIMIT   = 3'd2;
  localparam logic [2:0] CFG_POLL_LIMIT    = 3'd3;
  localparam logic [2:0] CFG_PWR_DELAY     = 3'd4;
  localparam logic [2:0] CFG_RST_DELAY     = 3'd5;
  localparam logic [2:0] CFG_ACT_DELAY     = 3'd6;
  localparam logic [2:0] CFG_IDLE_CLOCKS   = 3'd7;

  typedef struct packed {
    logic [7:0]  reset_tries;
    logic [9:0]  activate_tries;
    logic [16:0] token_wait_limit;
    logic [3:0]  response_poll_limit;
    logic [7:0]  powerup_delay_ms;
    logic [7:0]  reset_retry_delay_ms;
    logic [7:0]  activate_retry_delay_ms;
    logic [4:0]  idle_clock_bytes;
  } cfg_t;

  typedef struct packed {
    logic        spi_send;
    logic [7:0]  tx_byte;
    logic        select_active;
    logic [7:0]  delay_request_ms;
    logic        data_valid;
    logic [7:0]  data_byte;
    logic        data_last;
    logic        done_res;
    logic [2:0]  status;
    logic        high_capacity;
  } res_t;

endpackage
`default_nettype wire

// ----- src/sdspi_cfg.sv -----
`default_nettype none
module sdspi_cfg (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  cfg_valid,
  input  wire  [2:0]           cfg_index,
  input  wire  [16:0]          cfg_data,
  output sdspi_pkg::cfg_t      cfg
);
  import sdspi_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.reset_tries             <= 8'd10;
      cfg.activate_tries          <= 10'd1000;
      cfg.token_wait_limit        <= 17'd100000;
      cfg.response_poll_limit     <= 4'd8;
      cfg.powerup_delay_ms        <= 8'd10;
      cfg.reset_retry_delay_ms    <= 8'd10;
      cfg.activate_retry_delay_ms <= 8'd1;
      cfg.idle_clock_bytes        <= 5'd10;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_RESET_TRIES: cfg.reset_tries             <= cfg_data[7:0];
        CFG_ACT_TRIES:   cfg.activate_tries          <= cfg_data[9:0];
        CFG_TOKEN_LIMIT: cfg.token_wait_limit        <= cfg_data;
        CFG_POLL_LIMIT:  cfg.response_poll_limit     <= cfg_data[3:0];
        CFG_PWR_DELAY:   cfg.powerup_delay_ms        <= cfg_data[7:0];
        CFG_RST_DELAY:   cfg.reset_retry_delay_ms    <= cfg_data[7:0];
        CFG_ACT_DELAY:   cfg.activate_retry_delay_ms <= cfg_data[7:0];
        CFG_IDLE_CLOCKS: cfg.idle_clock_bytes        <= cfg_data[4:0];
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

// ----- src/sdspi_engine.sv -----
`default_nettype none
module sdspi_engine #(
  parameter int BLOCK_BYTES = sdspi_pkg::BlockBytesDefault
) (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  step,
  input  wire  [1:0]           action,
  input  wire  [31:0]          sector,
  input  wire  [7:0]           rx_byte,
  input  sdspi_pkg::cfg_t      cfg,
  output sdspi_pkg::res_t      res
);
  import sdspi_pkg::*;

  localparam int BW = $clog2(BLOCK_BYTES + 1);

  logic [3:0]  phase, phase_next;
  logic [BW-1:0] byte_counter, byte_counter_next;
  logic [3:0]  poll_counter, poll_counter_next;
  logic [9:0]  retry_counter, retry_counter_next;
  logic [16:0] token_counter, token_counter_next;
  logic [47:0] frame_shift, frame_shift_next;
  logic [7:0]  last_response, last_response_next;
  logic        echo_ok, echo_ok_next;
  logic        capacity_flag, capacity_flag_next;
  logic [5:0]  cur_cmd, cur_cmd_next;
  logic [2:0]  rel_next, rel_next_next;
  logic [1:0]  delay_kind, delay_kind_next;
  logic [2:0]  done_status, done_status_next;
  logic [7:0]  delay_ms, delay_ms_next;
  logic        dv;
  logic [7:0]  dbyte;
  logic        dlast;
  logic [31:0] addr;
  logic [7:0]  r;
  logic        ph_delay;
  logic [1:0]  cont_kind;
  logic        do_cont;
  logic [1:0]  dl_kind;
  logic [7:0]  dl_ms;
  logic        do_dl;
  logic        do_frame;
  logic [5:0]  fr_cmd;
  logic [31:0] fr_arg;
  logic [7:0]  fr_crc;
  logic        do_poll;
  logic        do_after;
  logic [3:0]  poll_inc;
  logic [16:0] token_inc;
  logic [BW-1:0] byte_inc;

  always_comb begin
    phase_next         = (phase == PH_DONE) ? PH_IDLE : phase;
    byte_counter_next  = byte_counter;
    poll_counter_next  = poll_counter;
    retry_counter_next = retry_counter;
    token_counter_next = token_counter;
    frame_shift_next   = frame_shift;
    last_response_next = last_response;
    echo_ok_next       = echo_ok;
    capacity_flag_next = capacity_flag;
    cur_cmd_next       = cur_cmd;
    rel_next_next      = rel_next;
    delay_kind_next    = delay_kind;
    done_status_next   = done_status;
    delay_ms_next      = delay_ms;
    dv = 1'b0; dbyte = 8'h00; dlast = 1'b0;
    do_cont = 1'b0; cont_kind = DL_PWR;
    do_dl = 1'b0; dl_kind = DL_PWR; dl_ms = 8'h00;
    do_frame = 1'b0; fr_cmd = CMD_GO_IDLE; fr_arg = 32'h0; fr_crc = 8'hFF;
    do_poll = 1'b0; do_after = 1'b0;
    poll_inc = poll_counter + 4'd1;
    token_inc = token_counter + 17'd1;
    byte_inc = byte_counter + BW'(1);
    r = last_response;
    addr = capacity_flag ? sector : (sector * 32'(BLOCK_BYTES));
    ph_delay = (phase == PH_DELAY);

    case (action)
      ACT_INIT: begin
        capacity_flag_next = 1'b0;
        retry_counter_next = 10'd0;
        last_response_next = 8'hFF;
        do_dl = 1'b1; dl_kind = DL_PWR; dl_ms = cfg.powerup_delay_ms;
      end
      ACT_READ: begin
        last_response_next = 8'hFF;
        do_frame = 1'b1; fr_cmd = CMD_READ; fr_arg = addr; fr_crc = 8'hFF;
      end
      ACT_DELAY: begin
        if (ph_delay) begin
          do_cont = 1'b1; cont_kind = delay_kind;
        end
      end
      default: begin
        case (phase)
          PH_CLK: begin
            byte_counter_next = byte_inc;
            if (byte_inc > BW'(cfg.idle_clock_bytes)) begin
              retry_counter_next = 10'd0;
              do_cont = 1'b1; cont_kind = DL_RST;
            end
          end
          PH_FRAME: begin
            byte_counter_next = byte_inc;
            frame_shift_next = {frame_shift[39:0], 8'h00};
            if (byte_inc >= BW'(6)) do_poll = 1'b1;
          end
          PH_POLL: begin
            if (!rx_byte[7]) begin
              last_response_next = rx_byte; r = rx_byte; do_after = 1'b1;
            end else begin
              poll_counter_next = poll_inc;
              if (poll_inc >= cfg.response_poll_limit) begin
                last_response_next = 8'hFF; r = 8'hFF; do_after = 1'b1;
              end
            end
          end
          PH_TRAIL: begin
            if (cur_cmd == CMD_IF_COND) begin
              if (byte_counter == BW'(2) && rx_byte != 8'h01) echo_ok_next = 1'b0;
              if (byte_counter == BW'(3) && rx_byte != 8'hAA) echo_ok_next = 1'b0;
            end else if (byte_counter == '0) begin
              echo_ok_next = rx_byte[6];
            end
            byte_counter_next = byte_inc;
            if (byte_inc >= BW'(4)) begin
              phase_next = PH_RELEASE;
              rel_next_next = (cur_cmd == CMD_IF_COND) ? RL_EVAL8 : RL_EVAL58;
            end
          end
          PH_RELEASE: begin
            case (rel_next)
              RL_EVAL0: begin
                if (r == 8'h01) begin
                  do_frame = 1'b1; fr_cmd = CMD_IF_COND; fr_arg = 32'h000001AA;
                  fr_crc = 8'h87;
                end else begin
                  retry_counter_next = retry_counter + 10'd1;
                  do_dl = 1'b1; dl_kind = DL_RST; dl_ms = cfg.reset_retry_delay_ms;
                end
              end
              RL_EVAL8: begin
                if (r == 8'h01 && echo_ok) begin
                  retry_counter_next = 10'd0;
                  do_cont = 1'b1; cont_kind = DL_ACT;
                end else begin
                  phase_next = PH_DONE; done_status_next = ST_CMD8;
                end
              end
              RL_AFTER55: begin
                if (r > 8'h01) rel_next_next = RL_EVAL41;
                else begin
                  do_frame = 1'b1; fr_cmd = CMD_OP_COND; fr_arg = 32'h40000000;
                end
              end
              RL_EVAL41: begin
                if (r == 8'h00) begin
                  do_frame = 1'b1; fr_cmd = CMD_READ_OCR;
                end else begin
                  retry_counter_next = retry_counter + 10'd1;
                  do_dl = 1'b1; dl_kind = DL_ACT; dl_ms = cfg.activate_retry_delay_ms;
                end
              end
              RL_EVAL58: begin
                phase_next = PH_DONE;
                if (r == 8'h00) begin
                  capacity_flag_next = echo_ok; done_status_next = ST_OK;
                end else done_status_next = ST_CMD58;
              end
              RL_FAIL5: begin phase_next = PH_DONE; done_status_next = ST_REJECT; end
              RL_FAIL6: begin phase_next = PH_DONE; done_status_next = ST_TOKEN; end
              default: begin phase_next = PH_DONE; done_status_next = ST_OK; end
            endcase
          end
          PH_TOKEN: begin
            if (rx_byte == 8'hFE) begin
              byte_counter_next = '0; phase_next = PH_DATA;
            end else begin
              token_counter_next = token_inc;
              if (token_inc >= cfg.token_wait_limit) begin
                phase_next = PH_RELEASE; rel_next_next = RL_FAIL6;
              end
            end
          end
          PH_DATA: begin
            dv = 1'b1; dbyte = rx_byte;
            byte_counter_next = byte_inc;
            if (byte_inc >= BW'(BLOCK_BYTES)) begin
              dlast = 1'b1; byte_counter_next = '0; phase_next = PH_CRC;
            end
          end
          PH_CRC: begin
            byte_counter_next = byte_inc;
            if (byte_inc >= BW'(2)) begin
              phase_next = PH_RELEASE; rel_next_next = RL_OK;
            end
          end
          default: ;
        endcase
      end
    endcase

    // zero delay folds into the continuation
    if (do_dl) begin
      if (dl_ms == 8'h00) begin
        do_cont = 1'b1; cont_kind = dl_kind;
      end else begin
        delay_kind_next = dl_kind; delay_ms_next = dl_ms; phase_next = PH_DELAY;
      end
    end

    if (do_cont) begin
      case (cont_kind)
        DL_PWR: begin byte_counter_next = '0; phase_next = PH_CLK; end
        DL_RST: begin
          if (retry_counter_next >= 10'(cfg.reset_tries)) begin
            phase_next = PH_DONE; done_status_next = ST_NO_IDLE;
          end else begin
            do_frame = 1'b1; fr_cmd = CMD_GO_IDLE; fr_arg = 32'h0; fr_crc = 8'h95;
          end
        end
        default: begin
          if (retry_counter_next >= cfg.activate_tries) begin
            phase_next = PH_DONE; done_status_next = ST_ACMD41;
          end else begin
            do_frame = 1'b1; fr_cmd = CMD_APP; fr_arg = 32'h0; fr_crc = 8'hFF;
          end
        end
      endcase
    end

    if (do_frame) begin
      cur_cmd_next = fr_cmd;
      frame_shift_next = {2'b01, fr_cmd, fr_arg, fr_crc};
      byte_counter_next = '0;
      phase_next = PH_FRAME;
    end

    if (do_poll) begin
      poll_counter_next = 4'd0;
      if (cfg.response_poll_limit == 4'd0) begin
        last_response_next = 8'hFF; r = 8'hFF; do_after = 1'b1;
      end else phase_next = PH_POLL;
    end

    if (do_after) begin
      case (cur_cmd)
        CMD_GO_IDLE: begin phase_next = PH_RELEASE; rel_next_next = RL_EVAL0; end
        CMD_APP:     begin phase_next = PH_RELEASE; rel_next_next = RL_AFTER55; end
        CMD_OP_COND: begin phase_next = PH_RELEASE; rel_next_next = RL_EVAL41; end
        CMD_IF_COND, CMD_READ_OCR: begin
          byte_counter_next = '0;
          echo_ok_next = (cur_cmd == CMD_IF_COND);
          phase_next = PH_TRAIL;
        end
        default: begin
          if (r != 8'h00) begin
            phase_next = PH_RELEASE; rel_next_next = RL_FAIL5;
          end else if (cfg.token_wait_limit == 17'd0) begin
            phase_next = PH_RELEASE; rel_next_next = RL_FAIL6;
          end else begin
            token_counter_next = 17'd0; phase_next = PH_TOKEN;
          end
        end
      endcase
    end
  end

  res_t res_next;
  always_comb begin
    res_next = '0;
    res_next.data_valid = dv;
    res_next.data_byte = dbyte;
    res_next.data_last = dlast;
    res_next.high_capacity = capacity_flag_next;
    case (phase_next)
      PH_DELAY: res_next.delay_request_ms = delay_ms_next;
      PH_DONE: begin
        res_next.done_res = 1'b1; res_next.status = done_status_next;
      end
      PH_IDLE: ;
      PH_CLK, PH_RELEASE: begin
        res_next.spi_send = 1'b1; res_next.tx_byte = 8'hFF;
      end
      PH_FRAME: begin
        res_next.spi_send = 1'b1; res_next.select_active = 1'b1;
        res_next.tx_byte = frame_shift_next[47:40];
      end
      default: begin
        res_next.spi_send = 1'b1; res_next.select_active = 1'b1;
        res_next.tx_byte = 8'hFF;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE; byte_counter <= '0; poll_counter <= '0; retry_counter <= '0;
      token_counter <= '0; frame_shift <= '0; last_response <= 8'hFF;
      echo_ok <= 1'b0; capacity_flag <= 1'b0; cur_cmd <= CMD_GO_IDLE;
      rel_next <= RL_EVAL0; delay_kind <= DL_PWR; done_status <= ST_OK;
      delay_ms <= 8'h00;
    end else if (step) begin
      phase <= phase_next; byte_counter <= byte_counter_next;
      poll_counter <= poll_counter_next; retry_counter <= retry_counter_next;
      token_counter <= token_counter_next; frame_shift <= frame_shift_next;
      last_response <= last_response_next; echo_ok <= echo_ok_next;
      capacity_flag <= capacity_flag_next; cur_cmd <= cur_cmd_next;
      rel_next <= rel_next_next; delay_kind <= delay_kind_next;
      done_status <= done_status_next; delay_ms <= delay_ms_next;
    end
  end

  always_ff @(posedge clk) begin
    if (step) res <= res_next;
  end

`ifndef ASSERT_OFF
  a_data_phase: assert property (@(posedge clk) disable iff (rst)
    step && dv && !dlast |=> phase == PH_DATA) else $error("data outside data phase");
  a_last_crc: assert property (@(posedge clk) disable iff (rst)
    step && dlast |=> phase == PH_CRC) else $error("last byte not followed by crc");
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    step && phase == PH_DONE && action != ACT_INIT && action != ACT_READ
    |=> phase == PH_IDLE) else $error("done not retired");
  a_read_frame: assert property (@(posedge clk) disable iff (rst)
    step && action == ACT_READ |=> phase == PH_FRAME && cur_cmd == CMD_READ)
    else $error("read start did not load a read frame");
`endif
endmodule
`default_nettype wire

// ----- src/sd_spi_init_and_block_read.sv -----
`default_nettype none
// sd card spi-mode host engine: init sequence and single block read
// in channel: in_valid/in_ready with action, sector, rx_byte; each request
//   is one event (start init, start read, spi byte received, delay elapsed)
// out channel: out_valid/out_ready; exactly one result per input request,
//   naming the next spi byte to clock, a delay to wait, data or completion
// cfg channel: cfg_valid/cfg_ready with cfg_index and cfg_data, always ready;
//   write only while no request is outstanding
// the result is registered and is valid in the cycle after input accept
// throughput: one request per cycle while results are taken; the next-state logic is a single pass
//   from the state registers to the result register
// when the receiver stalls the result register holds and in_ready drops
//   only while a result waits and is not being taken this cycle
// reset: synchronous, clears the engine to idle, the capacity flag to 0
//   and the config registers to their defaults
module sd_spi_init_and_block_read #(
  parameter int BLOCK_BYTES = sdspi_pkg::BlockBytesDefault
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         in_valid,
  output logic        in_ready,
  input  wire  [1:0]  action,
  input  wire  [31:0] sector,
  input  wire  [7:0]  rx_byte,
  output logic        out_valid,
  input  wire         out_ready,
  output logic        spi_send,
  output logic [7:0]  tx_byte,
  output logic        select_active,
  output logic [7:0]  delay_request_ms,
  output logic        data_valid,
  output logic [7:0]  data_byte,
  output logic        data_last,
  output logic        done_res,
  output logic [2:0]  status,
  output logic        high_capacity,
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire  [2:0]  cfg_index,
  input  wire  [16:0] cfg_data
);
  import sdspi_pkg::*;

  cfg_t cfg;
  res_t res;
  logic step;

  // result register refills when empty or being drained
  assign in_ready  = !out_valid || out_ready;
  assign step      = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  sdspi_cfg u_cfg (
    .clk(clk), .rst(rst), .cfg_valid(cfg_valid), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .cfg(cfg)
  );

  sdspi_engine #(.BLOCK_BYTES(BLOCK_BYTES)) u_engine (
    .clk(clk), .rst(rst), .step(step), .action(action), .sector(sector),
    .rx_byte(rx_byte), .cfg(cfg), .res(res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  assign spi_send         = res.spi_send;
  assign tx_byte          = res.tx_byte;
  assign select_active    = res.select_active;
  assign delay_request_ms = res.delay_request_ms;
  assign data_valid       = res.data_valid;
  assign data_byte        = res.data_byte;
  assign data_last        = res.data_last;
  assign done_res         = res.done_res;
  assign status           = res.status;
  assign high_capacity    = res.high_capacity;

`ifndef ASSERT_OFF
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(res))
    else $error("stalled result changed");
  a_fill: assert property (@(posedge clk) disable iff (rst)
    step |=> out_valid) else $error("accepted request lost");
  a_status: assert property (@(posedge clk) disable iff (rst)
    out_valid && !done_res |-> status == ST_OK) else $error("status without done");
`endif
endmodule
`default_nettype wire
